### rtl/core/ps2_mouse_packet_cursor_unit_macros.svh
// Assertion macros shared by the PS/2 mouse packet cursor RTL.
`ifndef PS2_MOUSE_PACKET_CURSOR_UNIT_MACROS_SVH
`define PS2_MOUSE_PACKET_CURSOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// A condition that must hold at every clock edge outside reset.
`define PS2MC_ASSERT(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
		else $error("ps2mc assertion failed");

// When the antecedent holds, the consequent must hold in the same cycle.
`define PS2MC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("ps2mc implication failed");

`else

`define PS2MC_ASSERT(label, clk, rst_n, cond)
`define PS2MC_ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`endif

`endif

### rtl/core/ps2mc_pkg.sv
// Package with the types and constants of the PS/2 mouse packet cursor unit.
package ps2mc_pkg;

	localparam int BYTE_W    = 8;
	localparam int BUTTON_W  = 3;
	localparam int CFG_IDX_W = 2;

	// Bit 3 of a header byte is always set by the mouse.
	localparam int HEADER_SYNC_BIT = 3;

	localparam logic [15:0] RESET_WIDTH  = 16'd800;
	localparam logic [15:0] RESET_HEIGHT = 16'd600;

	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_DELTA_X = 2'd1,
		PH_DELTA_Y = 2'd2
	} phase_t;

endpackage

### rtl/core/ps2mc_axis_clamp.sv
// Adds a signed delta to one pointer axis and clamps the result to the screen.
module ps2mc_axis_clamp #(
	parameter int COORD_WIDTH = 12
) (
	input  logic [COORD_WIDTH-1:0]   cursor,
	input  logic [7:0]               delta,
	input  logic                     negate,
	input  logic [COORD_WIDTH-1:0]   size,
	output logic [COORD_WIDTH-1:0]   pos
);
	logic [COORD_WIDTH+1:0] cur_ext;
	logic [COORD_WIDTH+1:0] dlt_ext;
	logic [COORD_WIDTH+1:0] sum;

	assign cur_ext = {2'b00, cursor};
	assign dlt_ext = {{(COORD_WIDTH-6){delta[7]}}, delta};
	assign sum     = negate ? (cur_ext - dlt_ext) : (cur_ext + dlt_ext);

	// The sum is signed; its top bit marks a move past the left or top edge.
	always_comb begin
		if ((size == '0) || sum[COORD_WIDTH+1]) begin
			pos = '0;
		end else if (sum[COORD_WIDTH:0] >= {1'b0, size}) begin
			pos = size - COORD_WIDTH'(1);
		end else begin
			pos = sum[COORD_WIDTH-1:0];
		end
	end
endmodule

### rtl/core/ps2_mouse_packet_cursor_unit.sv
// Top level of the PS/2 mouse packet cursor unit.
//
//   channel   direction  handshake                   payload
//   s_axis    in         s_axis_tvalid/s_axis_tready  tdata: data_byte
//   m_axis    out        m_axis_tvalid/m_axis_tready  tdata: pos_x, pos_y, button_bits
//   cfg       in         cfg_we                       cfg_addr, cfg_wdata
//
// Each byte is held in the input register and is decoded once the output
// register is free or being taken; a byte can be accepted in every cycle
// while the output is not stalled. Only the third byte of a packet produces
// an item, which lands in the output register. A stalled output holds at
// most one byte more in the input register before tready drops.
// Reset restores the 800 by 600 screen with the pointer centered.
module ps2_mouse_packet_cursor_unit #(
	parameter int COORD_WIDTH = 12
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// data_byte in bits 7:0
	input  logic [ps2mc_pkg::BYTE_W-1:0]           s_axis_tdata,
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	// pos_x, then pos_y, then button_bits, zero padded to whole bytes
	output logic [((2*COORD_WIDTH+ps2mc_pkg::BUTTON_W+7)/8)*8-1:0] m_axis_tdata,
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	input  logic                                   cfg_we,
	input  logic [ps2mc_pkg::CFG_IDX_W-1:0]        cfg_addr,
	input  logic [COORD_WIDTH-1:0]                 cfg_wdata
);
	import ps2mc_pkg::*;

	`include "ps2_mouse_packet_cursor_unit_macros.svh"

	localparam int OUT_BITS = 2*COORD_WIDTH + BUTTON_W;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	// Input register.
	logic              in_valid_s1;
	logic [BYTE_W-1:0] in_byte_s1;

	// Packet state.
	phase_t            phase_q, phase_d;
	logic [BYTE_W-1:0] header_q;
	logic [BYTE_W-1:0] delta_x_q;
	logic [COORD_WIDTH-1:0] width_q, height_q;
	logic [COORD_WIDTH-1:0] cursor_x_q, cursor_y_q;

	// Output register.
	logic                   out_valid_s2;
	logic [COORD_WIDTH-1:0] pos_x_s2, pos_y_s2;
	logic [BUTTON_W-1:0]    buttons_s2;

	logic advance;
	logic fire;
	logic emit;
	logic [COORD_WIDTH-1:0] new_x, new_y;

	// The decode step runs when the output register can take a new item.
	assign advance       = !out_valid_s2 || m_axis_tready;
	assign fire          = in_valid_s1 && advance;
	assign s_axis_tready = !in_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			in_byte_s1 <= s_axis_tdata;
		end
	end

	// Packet framing: the header must carry the sync bit, then two deltas.
	always_comb begin
		phase_d = phase_q;
		emit    = 1'b0;
		if (fire) begin
			case (phase_q)
				PH_DELTA_X: phase_d = PH_DELTA_Y;
				PH_DELTA_Y: begin
					phase_d = PH_HEADER;
					emit    = 1'b1;
				end
				default: phase_d = in_byte_s1[HEADER_SYNC_BIT] ? PH_DELTA_X : PH_HEADER;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
		end else begin
			phase_q <= phase_d;
		end
	end

	ps2mc_axis_clamp #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_clamp_x (
		.cursor (cursor_x_q),
		.delta  (delta_x_q),
		.negate (1'b0),
		.size   (width_q),
		.pos    (new_x)
	);

	// The mouse reports Y upward, so the screen Y moves the other way.
	ps2mc_axis_clamp #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_clamp_y (
		.cursor (cursor_y_q),
		.delta  (in_byte_s1),
		.negate (1'b1),
		.size   (height_q),
		.pos    (new_y)
	);

	// Screen size, pointer and the stored packet bytes. A size write recenters the
	// pointer on both axes. The user must do so with no byte in flight; not enforced.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q   <= '0;
			delta_x_q  <= '0;
			width_q    <= RESET_WIDTH[COORD_WIDTH-1:0];
			height_q   <= RESET_HEIGHT[COORD_WIDTH-1:0];
			cursor_x_q <= RESET_WIDTH[COORD_WIDTH-1:0] >> 1;
			cursor_y_q <= RESET_HEIGHT[COORD_WIDTH-1:0] >> 1;
		end else begin
			if (cfg_we && (cfg_addr == REG_SCREEN_WIDTH)) begin
				width_q    <= cfg_wdata;
				cursor_x_q <= cfg_wdata >> 1;
				cursor_y_q <= height_q >> 1;
			end else if (cfg_we && (cfg_addr == REG_SCREEN_HEIGHT)) begin
				height_q   <= cfg_wdata;
				cursor_x_q <= width_q >> 1;
				cursor_y_q <= cfg_wdata >> 1;
			end else if (emit) begin
				cursor_x_q <= new_x;
				cursor_y_q <= new_y;
			end
			if (fire && (phase_q == PH_DELTA_X)) begin
				delta_x_q <= in_byte_s1;
			end else if (fire && (phase_q != PH_DELTA_Y)) begin
				header_q <= in_byte_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (emit) begin
			out_valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			pos_x_s2   <= new_x;
			pos_y_s2   <= new_y;
			buttons_s2 <= header_q[BUTTON_W-1:0];
		end
	end

	assign m_axis_tvalid = out_valid_s2;
	assign m_axis_tdata  = {{(OUT_W-OUT_BITS){1'b0}}, buttons_s2, pos_y_s2, pos_x_s2};

	// The pointer never leaves the screen; an empty axis pins it at zero.
	`PS2MC_ASSERT(a_cursor_x_on_screen, clk, arst_n,
		(cursor_x_q < width_q) || ((width_q == '0) && (cursor_x_q == '0)))
	`PS2MC_ASSERT(a_cursor_y_on_screen, clk, arst_n,
		(cursor_y_q < height_q) || ((height_q == '0) && (cursor_y_q == '0)))
	// A new item only appears after the last byte of a packet was decoded.
	`PS2MC_ASSERT_IMPLY(a_item_after_third_byte, clk, arst_n,
		$rose(out_valid_s2), $past(phase_q == PH_DELTA_Y) && $past(fire))

endmodule
